### hw/rtl/bitmap_first_fit_allocator_macros.svh
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define BFFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared codes, types and reset constants of the allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam logic       OP_ALLOC = 1'b0;
	localparam logic       OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_RUN   = 2'd1;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

	localparam logic [31:0] REGION_BASE_RESET = 32'h0015_0000;

	localparam int COUNT_W = 13;
	localparam int ADDR_W  = 32;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACHK,
		S_SCAN,
		S_FCHK,
		S_FVAL,
		S_MARK,
		S_RESP
	} state_t;

	// command from the sequencer to the index walker
	typedef struct packed {
		logic load;
		logic step;
		logic down;
	} walk_cmd_t;

endpackage

### hw/rtl/bffa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/bffa_walk.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator index walker
// Shared step unit: one block index and a remaining count, moved by one
// each cycle it is stepped, for the clearing pass, bitmap scan and run marking.
// ----------------------------------------------------------------------------
module bffa_walk #(
	parameter int IW        = 12,
	parameter int XW        = 13,
	parameter int RESET_REM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bffa_pkg::walk_cmd_t cmd,
	input  logic [IW-1:0]      load_ptr,
	input  logic [XW-1:0]      load_rem,
	output logic [IW-1:0]      ptr,
	output logic               last,
	output logic               empty
);

	logic [IW-1:0] ptr_q;
	logic [XW-1:0] rem_q;
	logic          down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			rem_q  <= XW'(RESET_REM);
			down_q <= 1'b0;
		end else if (cmd.load) begin
			ptr_q  <= load_ptr;
			rem_q  <= load_rem;
			down_q <= cmd.down;
		end else if (cmd.step && (rem_q != '0)) begin
			ptr_q <= down_q ? (ptr_q - IW'(1)) : (ptr_q + IW'(1));
			rem_q <= rem_q - XW'(1);
		end
	end

	assign ptr   = ptr_q;
	assign last  = (rem_q == XW'(1));
	assign empty = (rem_q == '0);

endmodule

### hw/rtl/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Keeps one busy bit per block in a one-bit RAM. Allocate scans first-fit
// for the lowest free run of the requested length and marks it busy; free
// checks the address and marks the run free again.
//
//   channel   dir   handshake                  payload
//   s_axis    in    s_axis_tvalid/tready       tuser: op; tdata: count, addr
//   m_axis    out   m_axis_tvalid/tready       tdata: result_address, status
//   cfg       in    cfg_valid/cfg_ready        cfg_data: region_base
//
// After acceptance, allocate checks the count, reads the bitmap one bit a
// cycle up to the end of the run found (all NUM_BLOCKS bits on a miss) and
// marks that run busy block by block, or goes straight to the result on a
// bad count; free checks the address, then frees the run block by block.
// After reset a clearing pass over all NUM_BLOCKS bits holds s_axis_tready
// low; cfg is taken at any time. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted, and
// a stalled result holds the block before its own result.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_macros.svh"

module bitmap_first_fit_allocator #(
	parameter int NUM_BLOCKS  = 4096,
	parameter int BLOCK_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [12:0] block_count, [44:13] address, zero pad
	input  logic [0:0]  s_axis_tuser,   // [0] op
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] result_address, [33:32] status, zero pad
	// region base register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int XW = (CW > bffa_pkg::COUNT_W) ? CW : bffa_pkg::COUNT_W;
	localparam logic [31:0] ALIGN_MASK = 32'((64'd1 << BLOCK_SHIFT) - 64'd1);

	bffa_pkg::state_t    state_q, state_d;
	bffa_pkg::walk_cmd_t walk_cmd;

	logic [IW-1:0] walk_ptr, walk_load_ptr;
	logic [XW-1:0] walk_load_rem;
	logic          walk_last, walk_empty;

	logic          ram_wr_en, ram_rd_en;
	logic [IW-1:0] ram_wr_addr;
	logic [0:0]    ram_wr_data, ram_rd_data;

	// request held while it is worked on
	logic                          op_q;
	logic [bffa_pkg::COUNT_W-1:0]  count_q;
	logic [31:0]                   addr_q;
	logic [1:0]                    status_q;
	logic [IW-1:0]                 first_q;
	logic                          mis_q;
	logic [31:0]                   idx_q;
	logic [31:0]                   region_base_q;
	logic [CW-1:0]                 run_q;

	// scan read pipeline
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// result register
	logic        m_valid_q;
	logic [31:0] m_addr_q;
	logic [1:0]  m_status_q;

	logic in_accept;
	logic bad_count, bad_free, scan_hit, scan_end, scan_leave, out_free;
	logic [31:0] offset;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign offset    = addr_q - region_base_q;

	assign bad_count = (count_q == '0) || (XW'(count_q) > XW'(NUM_BLOCKS));
	assign bad_free  = mis_q || (idx_q >= 32'(NUM_BLOCKS))
		|| ((33'(idx_q) + 33'(count_q)) > 33'(NUM_BLOCKS));

	// a free bit that completes the run ends the scan; so does the last bit
	assign scan_hit   = vld_s1 && (ram_rd_data == 1'b0)
		&& ((XW'(run_q) + XW'(1)) == XW'(count_q));
	assign scan_end   = vld_s1 && (idx_s1 == IW'(NUM_BLOCKS - 1));
	assign scan_leave = scan_hit || scan_end;

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bffa_pkg::S_CLEAR: if (walk_last) state_d = bffa_pkg::S_IDLE;
			bffa_pkg::S_IDLE: begin
				if (in_accept) begin
					state_d = (s_axis_tuser[0] == bffa_pkg::OP_FREE)
						? bffa_pkg::S_FCHK : bffa_pkg::S_ACHK;
				end
			end
			bffa_pkg::S_ACHK: state_d = bad_count ? bffa_pkg::S_RESP : bffa_pkg::S_SCAN;
			bffa_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = bffa_pkg::S_MARK;
				end else if (scan_end) begin
					state_d = bffa_pkg::S_RESP;
				end
			end
			bffa_pkg::S_FCHK: state_d = bffa_pkg::S_FVAL;
			bffa_pkg::S_FVAL: begin
				state_d = (bad_free || (count_q == '0)) ? bffa_pkg::S_RESP : bffa_pkg::S_MARK;
			end
			bffa_pkg::S_MARK: if (walk_last) state_d = bffa_pkg::S_RESP;
			bffa_pkg::S_RESP: if (out_free) state_d = bffa_pkg::S_IDLE;
			default: state_d = bffa_pkg::S_CLEAR;
		endcase
	end

	// ------------------------------------------------------------------ outputs
	always_comb begin
		s_axis_tready = 1'b0;
		walk_cmd      = '0;
		walk_load_ptr = '0;
		walk_load_rem = XW'(NUM_BLOCKS);
		ram_wr_en     = 1'b0;
		ram_wr_addr   = walk_ptr;
		ram_wr_data   = 1'b0;
		ram_rd_en     = 1'b0;
		unique case (state_q)
			bffa_pkg::S_CLEAR: begin
				// sweep zeros through the whole bitmap
				ram_wr_en     = 1'b1;
				walk_cmd.step = 1'b1;
			end
			bffa_pkg::S_IDLE: s_axis_tready = 1'b1;
			bffa_pkg::S_ACHK: begin
				walk_cmd.load = 1'b1;
			end
			bffa_pkg::S_SCAN: begin
				ram_rd_en     = !walk_empty && !scan_leave;
				walk_cmd.step = ram_rd_en;
				if (scan_hit) begin
					// mark backwards from the end of the run found
					walk_cmd.load = 1'b1;
					walk_cmd.down = 1'b1;
					walk_load_ptr = idx_s1;
					walk_load_rem = XW'(count_q);
				end
			end
			bffa_pkg::S_FVAL: begin
				walk_cmd.load = 1'b1;
				walk_load_ptr = idx_q[IW-1:0];
				walk_load_rem = XW'(count_q);
			end
			bffa_pkg::S_MARK: begin
				ram_wr_en     = 1'b1;
				ram_wr_data   = (op_q == bffa_pkg::OP_ALLOC);
				walk_cmd.step = 1'b1;
			end
			bffa_pkg::S_FCHK, bffa_pkg::S_RESP: ;
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bffa_pkg::S_CLEAR;
			region_base_q <= bffa_pkg::REGION_BASE_RESET;
			vld_s1        <= 1'b0;
			m_valid_q     <= 1'b0;
			status_q      <= bffa_pkg::STATUS_OK;
			run_q         <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= ram_rd_en;
			if (cfg_valid && cfg_ready) begin
				region_base_q <= cfg_data;
			end
			if (in_accept) begin
				status_q <= bffa_pkg::STATUS_OK;
			end
			if (state_q == bffa_pkg::S_ACHK) begin
				run_q <= '0;
				if (bad_count) status_q <= bffa_pkg::STATUS_NO_RUN;
			end
			if ((state_q == bffa_pkg::S_SCAN) && vld_s1) begin
				run_q <= (ram_rd_data == 1'b0) ? (run_q + CW'(1)) : '0;
				if (scan_end && !scan_hit) status_q <= bffa_pkg::STATUS_NO_RUN;
			end
			if ((state_q == bffa_pkg::S_FVAL) && bad_free) begin
				status_q <= bffa_pkg::STATUS_BAD_ADDR;
			end
			// drop the result once taken, load the next when finished
			if ((state_q == bffa_pkg::S_RESP) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= walk_ptr;
		if (in_accept) begin
			op_q    <= s_axis_tuser[0];
			count_q <= s_axis_tdata[12:0];
			addr_q  <= s_axis_tdata[44:13];
		end
		if (state_q == bffa_pkg::S_FCHK) begin
			mis_q <= |(offset & ALIGN_MASK);
			idx_q <= offset >> BLOCK_SHIFT;
		end
		// walking down, the last block written is the first of the run
		if ((state_q == bffa_pkg::S_MARK) && walk_last) begin
			first_q <= walk_ptr;
		end
		if ((state_q == bffa_pkg::S_RESP) && out_free) begin
			m_status_q <= status_q;
			m_addr_q   <= ((op_q == bffa_pkg::OP_ALLOC) && (status_q == bffa_pkg::STATUS_OK))
				? (region_base_q + (32'(first_q) << BLOCK_SHIFT)) : 32'd0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_status_q, m_addr_q};

	// ---------------------------------------------------------------- instances
	bffa_walk #(
		.IW        (IW),
		.XW        (XW),
		.RESET_REM (NUM_BLOCKS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (walk_cmd),
		.load_ptr (walk_load_ptr),
		.load_rem (walk_load_rem),
		.ptr      (walk_ptr),
		.last     (walk_last),
		.empty    (walk_empty)
	);

	bffa_ram #(
		.WIDTH (1),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (walk_ptr),
		.rd_data (ram_rd_data)
	);

	// --------------------------------------------------------------- assertions
	`BFFA_ASSERT_NOW(a_port_excl, ram_wr_en, !ram_rd_en, "bitmap read and write collide")
	`BFFA_ASSERT_NOW(a_wr_range, ram_wr_en, 32'(ram_wr_addr) < 32'(NUM_BLOCKS), "bitmap write out of range")
	`BFFA_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tdata[33:32] != bffa_pkg::STATUS_OK), m_axis_tdata[31:0] == 32'd0, "failed result carries an address")
	`BFFA_ASSERT_NEXT(a_leave_idle, in_accept, state_q != bffa_pkg::S_IDLE, "accepted item not started")

endmodule
